/* hdl/timestamp_sync_interpolator_assert.svh */
// ----------------------------------------------------------------------------
// timestamp sync interpolator assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_SYNC_INTERPOLATOR_ASSERT_SVH
`define TIMESTAMP_SYNC_INTERPOLATOR_ASSERT_SVH

// expression must never be true
`define TSI_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tsi_pkg.sv */
// ----------------------------------------------------------------------------
// tsi_pkg
// shared types and constants of the timestamp sync interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tsi_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int TIME_W = 40;
  localparam int VEL_W  = 32;
  localparam int GAP_W  = 24;
  localparam logic [GAP_W-1:0] GAP_RST = 24'd200000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PREV = 2'd1;
  localparam logic [1:0] ST_GAP     = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  typedef struct packed {
    logic       push;
    logic       load;
    logic       rd_front;
    logic       rd_back;
    logic       pop;
    logic       eval;
    logic       copy;
    logic       mul_a;
    logic       mul_b;
    logic       sum;
    logic       div_step;
    logic       div_store;
    logic       emit;
    logic [1:0] status;
  } tsi_cmd_t;

  typedef struct packed {
    logic lt2;
    logic front_late;
    logic back_early;
    logic gap_bad;
    logic d_zero;
    logic div_last;
    logic axis_last;
  } tsi_stat_t;

endpackage
`default_nettype wire

/* hdl/tsi_ctrl.sv */
// ----------------------------------------------------------------------------
// tsi_ctrl
// sequencer for push, head trimming, gap checks and per-axis division
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsi_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                in_mode,
  input  tsi_pkg::tsi_stat_t st,
  output logic               busy,
  output tsi_pkg::tsi_cmd_t  cmd
);
  import tsi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RF   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_MA   = 4'd4;
  localparam logic [3:0] S_MB   = 4'd5;
  localparam logic [3:0] S_SM   = 4'd6;
  localparam logic [3:0] S_DV   = 4'd7;
  localparam logic [3:0] S_ST   = 4'd8;
  localparam logic [3:0] S_OK   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_mode) begin
            cmd.load  = 1'b1;
            state_nxt = S_RF;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      S_RF: begin
        if (st.lt2) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_SHORT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_front = 1'b1;
          state_nxt    = S_RB;
        end
      end
      S_RB: begin
        cmd.rd_back = 1'b1;
        state_nxt   = S_EV;
      end
      S_EV: begin
        if (st.front_late) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_NO_PREV;
          state_nxt  = S_IDLE;
        end else if (st.back_early) begin
          cmd.pop   = 1'b1;
          state_nxt = S_RF;
        end else if (st.gap_bad) begin
          cmd.pop    = 1'b1;
          cmd.emit   = 1'b1;
          cmd.status = ST_GAP;
          state_nxt  = S_IDLE;
        end else if (st.d_zero) begin
          cmd.copy  = 1'b1;
          state_nxt = S_OK;
        end else begin
          cmd.eval  = 1'b1;
          state_nxt = S_MA;
        end
      end
      S_MA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MB;
      end
      S_MB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_SM;
      end
      S_SM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_ST;
        end
      end
      S_ST: begin
        cmd.div_store = 1'b1;
        state_nxt     = st.axis_last ? S_OK : S_MA;
      end
      S_OK: begin
        cmd.emit   = 1'b1;
        cmd.status = ST_OK;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/tsi_dp.sv */
// ----------------------------------------------------------------------------
// tsi_dp
// sample store, fifo pointers, compares, multipliers and restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tsi_dp #(
  parameter int FIFO_DEPTH = tsi_pkg::FIFO_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tsi_pkg::tsi_cmd_t                cmd,
  output tsi_pkg::tsi_stat_t               st,
  input  wire                              cfg_we,
  input  wire [tsi_pkg::GAP_W-1:0]         cfg_data,
  input  wire [tsi_pkg::TIME_W-1:0]        in_time_us,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_x,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_y,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_z,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [tsi_pkg::TIME_W-1:0]       out_time,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_x,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_y,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_z
);
  import tsi_pkg::*;

  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int EW  = TIME_W + 3 * VEL_W;
  localparam int WW  = GAP_W + 1;
  localparam int PW  = VEL_W + WW;
  localparam int NW  = PW + 1;

  // sample store
  logic [EW-1:0]     mem [FIFO_DEPTH];
  logic [EW-1:0]     rd_q_r;
  logic [EW-1:0]     f_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     count_r;
  logic [SW-1:0]     wsum, hsum, bsum;
  logic [AW-1:0]     waddr, head_inc, baddr;

  logic [GAP_W-1:0]  gap_r;
  logic [TIME_W-1:0] t_r;

  // arithmetic
  logic [GAP_W-1:0]  wa_r, wb_r;
  logic [WW-1:0]     d_r;
  logic [1:0]        axis_r;
  logic [4:0]        dcnt_r;
  logic signed [PW-1:0] pa_r, pb_r;
  logic              neg_r;
  logic [WW-1:0]     rem_r;
  logic [VEL_W-1:0]  quo_r;
  logic [VEL_W-1:0]  res_r [3];

  logic [TIME_W-1:0] tf, tb, diff_f, diff_b;
  logic signed [VEL_W-1:0] vf, vb;
  logic signed [NW-1:0] num;
  logic [NW-1:0]     mag, dvd;
  logic [WW:0]       trial;
  logic              ge;

  assign tf = f_r[EW-1 -: TIME_W];
  assign tb = rd_q_r[EW-1 -: TIME_W];
  assign diff_f = t_r - tf;
  assign diff_b = tb - t_r;

  always_comb begin
    wsum = SW'(head_r) + SW'(count_r);
    if (wsum >= SW'(FIFO_DEPTH)) begin
      wsum = wsum - SW'(FIFO_DEPTH);
    end
    hsum = SW'(head_r) + SW'(1);
    if (hsum >= SW'(FIFO_DEPTH)) begin
      hsum = hsum - SW'(FIFO_DEPTH);
    end
    bsum = hsum;
  end

  // when full the new word lands on the oldest slot
  assign waddr    = (count_r == CW'(FIFO_DEPTH)) ? head_r : wsum[AW-1:0];
  assign head_inc = hsum[AW-1:0];
  assign baddr    = bsum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[waddr] <= {in_time_us, in_vel_z, in_vel_y, in_vel_x};
    end
    if (cmd.rd_front) begin
      rd_q_r <= mem[head_r];
    end else if (cmd.rd_back) begin
      rd_q_r <= mem[baddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      gap_r   <= GAP_RST;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_data;
      end
      if (cmd.push) begin
        if (count_r == CW'(FIFO_DEPTH)) begin
          head_r <= head_inc;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end else if (cmd.pop && count_r != '0) begin
        head_r  <= head_inc;
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= in_time_us;
    end
    if (cmd.rd_back) begin
      f_r <= rd_q_r;
    end
  end

  // status towards the sequencer
  always_comb begin
    st.lt2        = (count_r < CW'(2));
    st.front_late = (tf > t_r);
    st.back_early = (tb < t_r);
    st.gap_bad    = (diff_f > TIME_W'(gap_r)) || (diff_b > TIME_W'(gap_r));
    st.d_zero     = (tb == tf);
    st.div_last   = (dcnt_r == 5'd31);
    st.axis_last  = (axis_r == 2'd2);
  end

  always_comb begin
    case (axis_r)
      2'd0:    begin vf = f_r[VEL_W-1:0];           vb = rd_q_r[VEL_W-1:0];           end
      2'd1:    begin vf = f_r[2*VEL_W-1 -: VEL_W];  vb = rd_q_r[2*VEL_W-1 -: VEL_W];  end
      default: begin vf = f_r[3*VEL_W-1 -: VEL_W];  vb = rd_q_r[3*VEL_W-1 -: VEL_W];  end
    endcase
  end

  assign num   = {pa_r[PW-1], pa_r} + {pb_r[PW-1], pb_r};
  assign mag   = num[NW-1] ? NW'(-num) : NW'(num);
  assign dvd   = mag + NW'(d_r >> 1);
  assign trial = {rem_r, quo_r[VEL_W-1]} - {1'b0, d_r};
  assign ge    = !trial[WW];

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      // after the gap checks both weights fit the register width
      wa_r <= diff_b[GAP_W-1:0];
      wb_r <= diff_f[GAP_W-1:0];
      d_r  <= WW'(diff_b[GAP_W-1:0]) + WW'(diff_f[GAP_W-1:0]);
    end
    if (cmd.mul_a) begin
      pa_r <= vf * $signed({1'b0, wa_r});
    end
    if (cmd.mul_b) begin
      pb_r <= vb * $signed({1'b0, wb_r});
    end
    if (cmd.sum) begin
      // quotient fits 32 bits, so the top part already sits below the divisor
      neg_r <= num[NW-1];
      rem_r <= dvd[WW+VEL_W-1:VEL_W];
      quo_r <= dvd[VEL_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial[WW-1:0] : {rem_r[WW-2:0], quo_r[VEL_W-1]};
      quo_r <= {quo_r[VEL_W-2:0], ge};
    end
    if (cmd.div_store) begin
      res_r[axis_r] <= neg_r ? -quo_r : quo_r;
    end
    if (cmd.copy) begin
      res_r[0] <= f_r[VEL_W-1:0];
      res_r[1] <= f_r[2*VEL_W-1 -: VEL_W];
      res_r[2] <= f_r[3*VEL_W-1 -: VEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.eval) begin
        axis_r <= '0;
      end else if (cmd.div_store) begin
        axis_r <= axis_r + 2'd1;
      end
      if (cmd.sum) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 5'd1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_time   <= t_r;
      out_vel_x  <= (cmd.status == ST_OK) ? res_r[0] : '0;
      out_vel_y  <= (cmd.status == ST_OK) ? res_r[1] : '0;
      out_vel_z  <= (cmd.status == ST_OK) ? res_r[2] : '0;
    end
  end

`include "timestamp_sync_interpolator_assert.svh"

  `TSI_ASSERT_NEVER(a_count_range, count_r > CW'(FIFO_DEPTH), "fill count beyond depth")
  `TSI_ASSERT_NEVER(a_pop_empty, cmd.pop && count_r == '0, "pop of an empty store")
  `TSI_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `TSI_ASSERT_NEVER(a_fail_zero, out_valid && out_status != ST_OK &&
    (out_vel_x != '0 || out_vel_y != '0 || out_vel_z != '0), "failed sync with velocity")

endmodule
`default_nettype wire

/* hdl/timestamp_sync_interpolator.sv */
// ----------------------------------------------------------------------------
// timestamp_sync_interpolator
// fifo of timestamped velocity samples with linear interpolation at sync time
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     in_mode in_time_us in_vel_*    start, taken when busy is low
//  result    out_status out_time out_vel_*  out_valid, one cycle, no stall
//  config    cfg_data                       cfg_we, written at once
//
//  a push word leaves busy low, so the next word may follow
//  a sync word holds busy while the front and back samples are read and
//  checked, again for each sample trimmed off the head; it ends with no
//  read when fewer than two samples are held; equal stamps copy the front
//  sample; a successful blend runs per axis two multiplies, a sum, a 32 step
//  restoring divide and a store, then the result is issued
//  rst_n is synchronous; the store itself is not cleared, only its pointers
//  the receiver cannot stall: each result word is shown for exactly one cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module timestamp_sync_interpolator #(
  parameter int FIFO_DEPTH = tsi_pkg::FIFO_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input words
  input  wire                              start,
  output logic                             busy,
  input  wire                              in_mode,
  input  wire [tsi_pkg::TIME_W-1:0]        in_time_us,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_x,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_y,
  input  wire signed [tsi_pkg::VEL_W-1:0]  in_vel_z,
  // result words
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [tsi_pkg::TIME_W-1:0]       out_time,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_x,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_y,
  output logic signed [tsi_pkg::VEL_W-1:0] out_vel_z,
  // max gap register
  input  wire                              cfg_we,
  input  wire [tsi_pkg::GAP_W-1:0]         cfg_data
);
  import tsi_pkg::*;

  // commands down, compare and counter flags up
  tsi_cmd_t  cmd;
  tsi_stat_t st;

  // sequencer: trimming loop, gap checks, axis and divide steps
  tsi_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .st      (st),
    .busy    (busy),
    .cmd     (cmd)
  );

  // store, pointers, multipliers and divider shared by the axes, result register
  tsi_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_time_us (in_time_us),
    .in_vel_x   (in_vel_x),
    .in_vel_y   (in_vel_y),
    .in_vel_z   (in_vel_z),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_time   (out_time),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .out_vel_z  (out_vel_z)
  );

endmodule
`default_nettype wire

/* tb/sv/timestamp_sync_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// timestamp_sync_interpolator_tb
// Self-checking regression of the sample fifo and sync interpolator. A short
// table of directed words opens the run. Seeded random phases follow, each
// with its own max gap setting and sender idling. Sync results are checked
// field by field against the table or an in-bench fifo and blend predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module timestamp_sync_interpolator_tb;
  import tsi_pkg::*;

  localparam int DEPTH      = 16;
  localparam int LIMIT      = 2000000;
  localparam int PHASE_WRDS = 200;
  localparam int N_PHASES   = 6;
  localparam int EXP_DEPTH  = 4096;
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_SYNC = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [VEL_W-1:0]  VEL_MAX  = 32'h7fff_ffff;
  localparam logic [VEL_W-1:0]  VEL_MIN  = 32'h8000_0000;

  typedef struct {
    logic [1:0]        status;
    logic [TIME_W-1:0] t;
    logic [VEL_W-1:0]  vx, vy, vz;
  } result_t;

  typedef struct {
    logic              mode;
    logic [TIME_W-1:0] t;
    logic [VEL_W-1:0]  vx, vy, vz;
    bit                known;    // expected result typed in below
    logic [1:0]        status;
    logic [VEL_W-1:0]  ex, ey, ez;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [TIME_W-1:0] in_time_us = '0;
  logic [VEL_W-1:0]  in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [TIME_W-1:0] out_time;
  logic [VEL_W-1:0]  out_vel_x, out_vel_y, out_vel_z;
  logic cfg_we = 1'b0;
  logic [GAP_W-1:0] cfg_data = '0;

  timestamp_sync_interpolator #(.FIFO_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_time_us(in_time_us),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .out_valid(out_valid), .out_status(out_status), .out_time(out_time),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: its own copy of the sample fifo and the gap register
  logic [TIME_W-1:0] pred_time [DEPTH];
  logic [VEL_W-1:0]  pred_vel  [DEPTH][3];
  logic [3:0]        pred_head = '0;
  int                pred_count = 0;
  logic [GAP_W-1:0]  pred_gap = GAP_RST;

  // expected results in order, written at acceptance and read at the strobe
  result_t exp_mem [EXP_DEPTH];
  int      exp_wr = 0;
  int      exp_rd = 0;
  int      errors = 0;
  int      cycles = 0;
  int      idle_pct = 0;
  logic [TIME_W-1:0] now_us = '0;   // running timestamp of the random stream

  // rounded blend, ties away from zero; weights are bounded by the gap
  function automatic logic [VEL_W-1:0] blend(longint vf, longint vb,
                                             longint wf, longint wb, longint d);
    longint num, mag, q;
    num = vf * wf + vb * wb;
    mag = (num < 0) ? -num : num;
    q   = (mag + d / 2) / d;
    return (num < 0) ? VEL_W'(-q) : VEL_W'(q);
  endfunction

  task automatic predict_word(input logic mode, input logic [TIME_W-1:0] t,
                              input logic [VEL_W-1:0] vx, vy, vz,
                              output bit has_res, output result_t r);
    logic [3:0] w, fi, bi;
    logic [TIME_W-1:0] tf, tb;
    longint d;
    bit done;
    has_res = 0;
    r = '{ST_OK, t, '0, '0, '0};
    done = 0;
    if (mode == MODE_PUSH) begin
      // full fifo: oldest sample is dropped
      if (pred_count >= DEPTH) begin
        pred_head = pred_head + 4'd1;
        pred_count--;
      end
      w = pred_head + 4'(pred_count);
      pred_time[w] = t;
      pred_vel[w][0] = vx;
      pred_vel[w][1] = vy;
      pred_vel[w][2] = vz;
      pred_count++;
    end else begin
      has_res = 1;
      while (!done) begin
        fi = pred_head;
        bi = pred_head + 4'd1;
        if (pred_count < 2) begin
          r.status = ST_SHORT;
          done = 1;
        end else begin
          tf = pred_time[fi];
          tb = pred_time[bi];
          if (tf > t) begin
            r.status = ST_NO_PREV;
            done = 1;
          end else if (tb < t) begin
            pred_head = bi;
            pred_count--;
          end else if (t - tf > TIME_W'(pred_gap) || tb - t > TIME_W'(pred_gap)) begin
            pred_head = bi;
            pred_count--;
            r.status = ST_GAP;
            done = 1;
          end else begin
            d = longint'(tb - tf);
            if (d == 0) begin
              // equal bracketing stamps give the front sample back
              r.vx = pred_vel[fi][0];
              r.vy = pred_vel[fi][1];
              r.vz = pred_vel[fi][2];
            end else begin
              r.vx = blend($signed(pred_vel[fi][0]), $signed(pred_vel[bi][0]),
                           longint'(tb - t), longint'(t - tf), d);
              r.vy = blend($signed(pred_vel[fi][1]), $signed(pred_vel[bi][1]),
                           longint'(tb - t), longint'(t - tf), d);
              r.vz = blend($signed(pred_vel[fi][2]), $signed(pred_vel[bi][2]),
                           longint'(tb - t), longint'(t - tf), d);
            end
            r.status = ST_OK;
            done = 1;
          end
        end
      end
    end
  endtask

  // drive one word, hold it until taken, then predict it
  task automatic send_word(input stim_row_t row);
    bit has_res;
    result_t r;
    start      <= 1'b1;
    in_mode    <= row.mode;
    in_time_us <= row.t;
    in_vel_x   <= row.vx;
    in_vel_y   <= row.vy;
    in_vel_z   <= row.vz;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_word(row.mode, row.t, row.vx, row.vy, row.vz, has_res, r);
    if (has_res) begin
      if (row.known) r = '{row.status, row.t, row.ex, row.ey, row.ez};
      exp_mem[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
    end
    // random sender gaps; start only drops when a gap is taken
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // quiet point: every result in, then a margin for a trailing push
  task automatic drain();
    start <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] g);
    cfg_we   <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we   <= 1'b0;
    pred_gap = g;
  endtask

  function automatic logic [VEL_W-1:0] rand_vel();
    case ($urandom_range(0, 9))
      0:       return VEL_MAX;
      1:       return VEL_MIN;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {8'($urandom()), 32'($urandom())};
  endfunction

  // mostly ordered streams with syncs near the newest samples, some noise
  function automatic stim_row_t rand_row(input logic [TIME_W-1:0] step);
    stim_row_t row;
    row = '{MODE_PUSH, '0, rand_vel(), rand_vel(), rand_vel(), 0, ST_OK, '0, '0, '0};
    if ($urandom_range(0, 99) < 35) begin
      row.mode = MODE_SYNC;
      row.t = now_us - TIME_W'($urandom_range(0, 32'(step) * 3));
      if ($urandom_range(0, 99) < 5) row.t = now_us + TIME_W'($urandom_range(0, 32'(step)));
    end else begin
      now_us = now_us + TIME_W'($urandom_range(0, 32'(step)));
      row.t = now_us;
    end
    if ($urandom_range(0, 99) < 4) row.t = rand_time();
    if ($urandom_range(0, 199) == 0) begin
      now_us = rand_time();
      row.t = now_us;
    end
    return row;
  endfunction

  // directed table: reset state, extremes, every status and the special cases
  stim_row_t dir_tab[] = '{
    '{MODE_SYNC, 40'd100,  '0, '0, '0, 1, ST_SHORT, '0, '0, '0},
    '{MODE_PUSH, 40'd1000, VEL_MAX, VEL_MAX, VEL_MAX, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd1000, '0, '0, '0, 1, ST_SHORT, '0, '0, '0},
    '{MODE_PUSH, 40'd2000, VEL_MIN, VEL_MIN, VEL_MIN, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd500,  '0, '0, '0, 1, ST_NO_PREV, '0, '0, '0},
    '{MODE_SYNC, 40'd1000, '0, '0, '0, 1, ST_OK, VEL_MAX, VEL_MAX, VEL_MAX},
    '{MODE_SYNC, 40'd2000, '0, '0, '0, 1, ST_OK, VEL_MIN, VEL_MIN, VEL_MIN},
    '{MODE_SYNC, 40'd1500, '0, '0, '0, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd1250, '0, '0, '0, 0, ST_OK, '0, '0, '0},
    // trims the head down to one sample
    '{MODE_SYNC, 40'd2500, '0, '0, '0, 1, ST_SHORT, '0, '0, '0},
    // equal bracketing stamps
    '{MODE_PUSH, 40'd2000, 32'd5, 32'd6, 32'd7, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd2000, '0, '0, '0, 1, ST_OK, VEL_MIN, VEL_MIN, VEL_MIN},
    // neighbour too far away
    '{MODE_PUSH, 40'd302000, 32'd1, 32'd2, 32'd3, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd302000, '0, '0, '0, 1, ST_GAP, '0, '0, '0},
    '{MODE_PUSH, 40'd302100, 32'h0001_0000, 32'hffff_0000, VEL_MAX, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, 40'd302033, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, ST_OK,
      '0, '0, '0},
    // top of the time range
    '{MODE_PUSH, TIME_MAX - 40'd10, VEL_MIN, VEL_MAX, 32'd0, 0, ST_OK, '0, '0, '0},
    '{MODE_PUSH, TIME_MAX, VEL_MAX, VEL_MIN, 32'hffff_ffff, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, TIME_MAX - 40'd3, '0, '0, '0, 0, ST_OK, '0, '0, '0},
    '{MODE_SYNC, TIME_MAX, '0, '0, '0, 0, ST_OK, '0, '0, '0}
  };

  // result checker: the receiver cannot stall, so every strobe is a result
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result word status %0d time %0d", $time,
                 out_status, out_time);
        errors++;
      end else begin
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_time !== e.t) begin
          $display("%0t: time expected %0d actual %0d", $time, e.t, out_time);
          errors++;
        end
        if (out_vel_x !== e.vx) begin
          $display("%0t: vel_x expected %h actual %h", $time, e.vx, out_vel_x);
          errors++;
        end
        if (out_vel_y !== e.vy) begin
          $display("%0t: vel_y expected %h actual %h", $time, e.vy, out_vel_y);
          errors++;
        end
        if (out_vel_z !== e.vz) begin
          $display("%0t: vel_z expected %h actual %h", $time, e.vz, out_vel_z);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timestamp_sync_interpolator regression: fail");
      $finish;
    end
  end

  initial begin
    logic [GAP_W-1:0] gaps [N_PHASES];
    int pct [N_PHASES];
    logic [TIME_W-1:0] step;
    gaps = '{24'd0, 24'hff_ffff, 24'd1000, 24'd50, 24'(GAP_RST), 24'd0};
    pct  = '{0, 79, 0, 20, 79, 0};
    gaps[5] = 24'($urandom());
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs on the reset value of the gap register
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    // overfill the fifo so the oldest samples are dropped
    for (int i = 0; i < DEPTH + 3; i++)
      send_word('{MODE_PUSH, 40'd400000 + 40'(i * 100), rand_vel(), rand_vel(),
                  rand_vel(), 0, ST_OK, '0, '0, '0});
    send_word('{MODE_SYNC, 40'd401250, '0, '0, '0, 0, ST_OK, '0, '0, '0});
    drain();
    now_us = 40'd500000;

    for (int p = 0; p < N_PHASES; p++) begin
      // register written only at a quiet point
      write_gap(gaps[p]);
      idle_pct = pct[p];
      step = (gaps[p] == 0) ? 40'd2 : TIME_W'(gaps[p] / 2 + 1);
      for (int n = 0; n < PHASE_WRDS; n++) send_word(rand_row(step));
      // sender holds off until every result has come
      drain();
    end

    if (errors == 0)
      $display("timestamp_sync_interpolator regression: pass");
    else
      $display("timestamp_sync_interpolator regression: fail");
    $finish;
  end

endmodule
